// ===== sv/crossing_number_minutiae_macros.svh =====
// Assertion macros used by the minutiae queue module.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef CROSSING_NUMBER_MINUTIAE_MACROS_SVH
`define CROSSING_NUMBER_MINUTIAE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CNM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cnm check failed");
`define CNM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cnm check failed");
`else
`define CNM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CNM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/cnm_pkg.sv =====
// Types and constants of the crossing-number minutiae extractor.
// No dependencies; imported by every module of the block.
package cnm_pkg;

    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int POS_W      = 10;
    localparam int ORIENT_W   = 15;
    localparam int ANGLE_W    = 16;
    localparam int QUAL_W     = 8;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 48;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    localparam logic [ANGLE_W-1:0] HALF_PI_Q12     = 16'd6434;
    localparam logic [QUAL_W-1:0]  QUALITY_OUTSIDE = 8'd254;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_QUALITY_WIDTH  = 2'd2,
        REG_QUALITY_HEIGHT = 2'd3
    } cnm_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic [CFG_W-1:0] quality_width;
        logic [CFG_W-1:0] quality_height;
    } cnm_cfg_t;

    // one classified minutia waiting in the queue
    typedef struct packed {
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic                kind;
        logic [ORIENT_W-1:0] orientation;
        logic [QUAL_W-1:0]   quality;
        logic                outside;
    } cnm_cand_t;

    typedef struct packed {
        logic            head_valid;
        logic [Q_CW-1:0] level;
    } cnm_qstat_t;

endpackage

// ===== sv/cnm_front.sv =====
// Front end: pixel counters, line memory, 3x3 window and crossing-number test.
// Pushes classified minutiae into the queue; depends on cnm_pkg.
module cnm_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cnm_pkg::cnm_cfg_t                    cfg,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_ridge,
    input  logic [cnm_pkg::ORIENT_W-1:0]         s_orient,
    input  logic [cnm_pkg::QUAL_W-1:0]           s_qual,
    input  cnm_pkg::cnm_qstat_t                  qstat,
    output logic                                 push,
    output cnm_pkg::cnm_cand_t                   cand
);
    import cnm_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int SWH = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
    localparam int QWX = (CW > CFG_W) ? CW : CFG_W;
    localparam int QWY = (RW > CFG_W) ? RW : CFG_W;
    localparam int LW  = 2 + ORIENT_W + QUAL_W;
    localparam logic [SWW-1:0] MAXW_S = SWW'(MAX_WIDTH);
    localparam logic [SWH-1:0] MAXH_S = SWH'(MAX_HEIGHT);

    // line word: [LW-1] row r-1 ridge, [LW-2] row r-2 ridge, orientation, quality
    logic [LW-1:0] line_mem [MAX_WIDTH];

    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic                s1_valid_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [RW-1:0]       s1_row_reg;
    logic                s1_ridge_reg;
    logic [ORIENT_W-1:0] s1_orient_reg;
    logic [QUAL_W-1:0]   s1_qual_reg;
    logic [LW-1:0]       rd_word_reg;
    logic                fwd_hit_reg;
    logic [LW-1:0]       fwd_word_reg;
    logic [8:0]          win_reg, win_next;
    logic [ORIENT_W+QUAL_W-1:0] attr_reg;

    logic           accept;
    logic [SWW-1:0] w_ext, eff_w, col_inc;
    logic [SWH-1:0] h_ext, eff_h, row_inc;
    logic [LW-1:0]  line_word, wr_word;
    logic [2:0]     column;
    logic [7:0]     ring;
    logic [3:0]     changes;
    logic [2:0]     half;
    logic [CW-1:0]  px;
    logic [RW-1:0]  py;
    logic           hit;

    assign s_ready = (qstat.level + Q_CW'(s1_valid_reg)) < Q_CW'(Q_DEPTH);
    assign accept  = s_valid && s_ready;

    always_comb begin
        w_ext   = SWW'(cfg.image_width);
        h_ext   = SWH'(cfg.image_height);
        eff_w   = (w_ext > MAXW_S) ? MAXW_S : ((w_ext == '0) ? SWW'(1) : w_ext);
        eff_h   = (h_ext > MAXH_S) ? MAXH_S : ((h_ext == '0) ? SWH'(1) : h_ext);
        col_inc = SWW'(col_reg) + SWW'(1);
        row_inc = SWH'(row_reg) + SWH'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_inc >= eff_w) begin
                col_next = '0;
                row_next = (row_inc >= eff_h) ? '0 : RW'(row_inc);
            end else begin
                col_next = CW'(col_inc);
            end
        end
    end

    always_comb begin
        line_word = fwd_hit_reg ? fwd_word_reg : rd_word_reg;
        wr_word   = {s1_ridge_reg, line_word[LW-1], s1_orient_reg, s1_qual_reg};
        column    = {s1_ridge_reg, line_word[LW-1], line_word[LW-2]};
        win_next  = {column, win_reg[8:3]};
        ring      = {win_next[3], win_next[6], win_next[7], win_next[8],
                     win_next[5], win_next[2], win_next[1], win_next[0]};
        changes   = '0;
        for (int k = 0; k < 8; k++) begin
            changes = changes + 4'(ring[k] ^ ring[(k + 1) % 8]);
        end
        half = changes[3:1];
        px   = s1_col_reg - CW'(1);
        py   = s1_row_reg - RW'(1);
        hit  = (s1_row_reg >= RW'(2)) && (s1_col_reg >= CW'(2)) && win_next[4]
               && ((half == 3'd1) || (half == 3'd3));
    end

    assign push             = s1_valid_reg && hit;
    assign cand.pos_x       = POS_W'(px);
    assign cand.pos_y       = POS_W'(py);
    assign cand.kind        = (half == 3'd3);
    assign cand.orientation = attr_reg[ORIENT_W+QUAL_W-1:QUAL_W];
    assign cand.quality     = attr_reg[QUAL_W-1:0];
    assign cand.outside     = !((QWX'(px) < QWX'(cfg.quality_width))
                                && (QWY'(py) < QWY'(cfg.quality_height)));

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= wr_word;
        end
        if (accept) begin
            rd_word_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            win_reg      <= '0;
            attr_reg     <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            if (accept) begin
                fwd_hit_reg <= s1_valid_reg && (col_reg == s1_col_reg);
            end
            if (s1_valid_reg) begin
                win_reg  <= win_next;
                attr_reg <= line_word[ORIENT_W+QUAL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
            s1_ridge_reg  <= s_ridge;
            s1_orient_reg <= s_orient;
            s1_qual_reg   <= s_qual;
            fwd_word_reg  <= wr_word;
        end
    end

endmodule

// ===== sv/cnm_queue.sv =====
// Short queue of classified minutiae between the front and back ends.
// Depends on cnm_pkg and the assertion macro header.
`include "crossing_number_minutiae_macros.svh"

module cnm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cnm_pkg::cnm_cand_t    push_data,
    input  logic                  pop,
    output cnm_pkg::cnm_cand_t    head,
    output cnm_pkg::cnm_qstat_t   qstat
);
    import cnm_pkg::*;

    cnm_cand_t       slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] count_reg, count_next;

    assign head             = slot_reg[rd_ptr_reg];
    assign qstat.head_valid = (count_reg != '0);
    assign qstat.level      = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + Q_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    `CNM_ASSERT_IMP(a_no_overflow, aclk, aresetn, push, count_reg < Q_CW'(Q_DEPTH))
    `CNM_ASSERT_IMP(a_no_underflow, aclk, aresetn, pop, count_reg != '0)
    `CNM_ASSERT_NXT(a_level_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + Q_CW'(1))

endmodule

// ===== sv/cnm_back.sv =====
// Back end: angle offset, quality substitution and the result register.
// Depends on cnm_pkg.
module cnm_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cnm_pkg::cnm_cand_t                 head,
    input  cnm_pkg::cnm_qstat_t                qstat,
    output logic                               pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [cnm_pkg::M_DATA_W-1:0]       m_data,
    output logic                               m_kind
);
    import cnm_pkg::*;

    localparam int PAD_W = M_DATA_W - 2 * POS_W - ANGLE_W - QUAL_W;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_kind_reg;
    logic [ANGLE_W-1:0]  angle;
    logic [QUAL_W-1:0]   quality;

    assign pop     = qstat.head_valid && (!m_valid_reg || m_ready);
    assign angle   = {head.orientation[ORIENT_W-1], head.orientation} + HALF_PI_Q12;
    assign quality = head.outside ? QUALITY_OUTSIDE : head.quality;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= {PAD_W'(0), quality, angle, head.pos_y, head.pos_x};
            m_kind_reg <= head.kind;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_kind  = m_kind_reg;

endmodule

// ===== sv/crossing_number_minutiae.sv =====
// Crossing-number minutiae extractor for a thinned fingerprint skeleton.
// Feed pixels in raster order on the s_ stream, one beat per pixel: tdata
// carries the ridge bit, the Q3.12 orientation and the quality byte. Each
// ridge-ending or bifurcation found comes out as one beat on the m_ stream,
// with position, orientation plus pi/2 and quality (254 outside the map),
// and the kind in tuser. A centre pixel is tested when the pixel one row
// and one column after it is accepted; its beat passes through the queue to
// the result register. One pixel is taken per cycle while the queue has room:
// the line memory is read for the accepted pixel and written for the pixel
// before it in the same cycle, and the four-entry result queue lets the input
// run on while the receiver stalls until the queue fills. Border pixels never
// produce a beat. Image and quality-map sizes must be written through
// cfg_we/cfg_addr/cfg_wdata between frames while the block is idle; the block
// does not enforce this. Synchronous reset sets all sizes to 1024 and the pixel
// position to the first pixel of a frame; the line memory needs no clearing pass.
// Depends on cnm_pkg, cnm_front, cnm_queue and cnm_back.
module crossing_number_minutiae #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cnm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [cnm_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ridge_pixel [0], orientation [15:1], quality_value [23:16]
    input  logic [cnm_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pos_x [9:0], pos_y [19:10], angle [35:20], quality_out [43:36], zero [47:44]
    output logic [cnm_pkg::M_DATA_W-1:0]        m_tdata,
    // kind [0]
    output logic                                m_tuser
);
    import cnm_pkg::*;

    cnm_cfg_t   cfg_reg;
    logic       push, pop;
    cnm_cand_t  cand, head;
    cnm_qstat_t qstat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width    <= CFG_W'(1024);
            cfg_reg.image_height   <= CFG_W'(1024);
            cfg_reg.quality_width  <= CFG_W'(1024);
            cfg_reg.quality_height <= CFG_W'(1024);
        end else if (cfg_we) begin
            unique case (cnm_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_wdata;
                REG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_wdata;
                REG_QUALITY_WIDTH:  cfg_reg.quality_width  <= cfg_wdata;
                REG_QUALITY_HEIGHT: cfg_reg.quality_height <= cfg_wdata;
                default: ;
            endcase
        end
    end

    cnm_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_ridge (s_tdata[0]),
        .s_orient(s_tdata[ORIENT_W:1]),
        .s_qual  (s_tdata[ORIENT_W+QUAL_W:ORIENT_W+1]),
        .qstat   (qstat),
        .push    (push),
        .cand    (cand)
    );

    cnm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(cand),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    cnm_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .m_valid(m_tvalid),
        .m_ready(m_tready),
        .m_data (m_tdata),
        .m_kind (m_tuser)
    );

endmodule
